// ===== sv/ptdp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptdp_pkg
// Shared types and constants for the prefix tree depth pruner: transaction
// payloads, status codes and the controller to datapath command and status.
// ----------------------------------------------------------------------------
package ptdp_pkg;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_OVF = 2'd1;
    localparam logic [1:0] STATUS_MAL = 2'd2;

    typedef struct packed {
        logic [31:0] token_id;
        logic [15:0] arity;
        logic        is_apply;
        logic        last_token;
    } in_item_t;

    typedef struct packed {
        logic        keep;
        logic [31:0] out_token_id;
        logic [15:0] out_arity;
        logic [15:0] kept_count;
        logic        formula_end;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic take;
        logic read;
        logic check;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic tok_need_read;
        logic chk_need_read;
    } dp_stat_t;

endpackage

// ===== sv/ptdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptdp_ctrl
// Controller: accepts tokens, sequences stack reloads and pop cascades, and
// tells the datapath when a result is complete.
// ----------------------------------------------------------------------------
module ptdp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              m_ready,
    input  ptdp_pkg::dp_stat_t stat,
    output ptdp_pkg::ctl_cmd_t cmd
);
    import ptdp_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == ST_IDLE) && (!stat.out_busy || m_ready);

    always_comb begin
        cmd.take   = s_valid && s_ready;
        cmd.read   = (state_reg == ST_READ);
        cmd.check  = (state_reg == ST_CHECK);
        cmd.finish = (cmd.take && !stat.tok_need_read)
                   || (cmd.check && !stat.chk_need_read);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.take && stat.tok_need_read) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = stat.chk_need_read ? ST_READ : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/ptdp_datapath.sv =====
// ----------------------------------------------------------------------------
// ptdp_datapath
// Datapath: open-node stack (cached top plus memory), pending-subtree
// counter, kept counter, cutoff register and the result register.
// ----------------------------------------------------------------------------
module ptdp_datapath #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ptdp_pkg::in_item_t  s_data,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_data,
    input  logic                m_ready,
    output logic                m_valid,
    output ptdp_pkg::out_item_t m_data,
    input  ptdp_pkg::ctl_cmd_t  cmd,
    output ptdp_pkg::dp_stat_t  stat
);
    import ptdp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int SW = $clog2(STACK_DEPTH + 1);
    localparam int CW = (SW > 8) ? SW : 8;

    logic [15:0] cnt_mem   [STACK_DEPTH];
    logic        first_mem [STACK_DEPTH];

    logic [SW-1:0] size_reg;
    logic [31:0]   skip_reg;
    logic [15:0]   kept_reg;
    logic          at_root_reg;
    logic [7:0]    md_reg;
    logic          cont_reg;
    logic          m_valid_reg;
    logic          m_valid_next;
    out_item_t     m_data_reg;
    logic [15:0]   top_cnt_reg;
    logic          top_first_reg;
    logic          mal_pend_reg;
    logic          ovf_pend_reg;
    logic [15:0]   rd_cnt_reg;
    logic          rd_first_reg;

    logic [SW-1:0] size_m1;
    logic [AW-1:0] top_addr;

    // token step
    logic          do_drop;
    logic          do_keep;
    logic          do_reload;
    logic          do_close;
    logic [31:0]   d_base;
    logic [32:0]   d_sum;
    logic          wr_en;
    logic [SW-1:0] t_size;
    logic [31:0]   t_skip;
    logic [15:0]   t_kept;
    logic [15:0]   t_top_cnt;
    logic          t_top_first;
    logic          t_keep;
    logic          t_ovf;
    logic          t_mal;
    logic          t_need_read;
    logic          t_cont;

    // cascade check step
    logic [SW-1:0] c_size;
    logic [15:0]   c_top_cnt;
    logic          c_top_first;
    logic          c_need_read;

    // completion
    logic          last_cur;
    logic [SW-1:0] f_size;
    logic [31:0]   f_skip;
    logic          mal_fin;
    logic          ovf_fin;
    logic [1:0]    status_fin;

    assign size_m1  = size_reg - 1'b1;
    assign top_addr = size_m1[AW-1:0];

    always_comb begin
        do_drop     = 1'b0;
        do_keep     = 1'b0;
        do_reload   = 1'b0;
        do_close    = 1'b0;
        d_base      = skip_reg;
        wr_en       = 1'b0;
        t_size      = size_reg;
        t_skip      = skip_reg;
        t_kept      = kept_reg;
        t_top_cnt   = top_cnt_reg;
        t_top_first = top_first_reg;
        t_keep      = 1'b0;
        t_ovf       = 1'b0;
        t_mal       = 1'b0;
        t_need_read = 1'b0;
        t_cont      = 1'b0;

        if (at_root_reg) begin
            if (md_reg == 8'd0) begin
                do_drop = 1'b1;
                d_base  = 32'd1;
            end else begin
                do_keep = 1'b1;
            end
        end else if (size_reg == '0 && skip_reg == 32'd0) begin
            t_mal = 1'b1;
        end else if (skip_reg != 32'd0) begin
            do_drop = 1'b1;
        end else if (CW'(size_reg) >= CW'(md_reg) && !top_first_reg) begin
            do_drop   = 1'b1;
            do_reload = 1'b1;
            d_base    = 32'(top_cnt_reg);
            t_size    = size_m1;
        end else begin
            do_keep = 1'b1;
        end

        d_sum = {1'b0, d_base} + 33'(s_data.arity) - 33'd1;

        if (do_drop) begin
            t_skip   = d_sum[32] ? 32'hFFFF_FFFF : d_sum[31:0];
            t_ovf    = d_sum[32];
            do_close = (d_sum == 33'd0);
        end

        if (do_keep) begin
            t_keep = 1'b1;
            t_kept = (kept_reg == 16'hFFFF) ? kept_reg : kept_reg + 16'd1;
            if (s_data.arity == 16'd0) begin
                do_close = 1'b1;
            end else if (size_reg >= SW'(STACK_DEPTH)) begin
                t_ovf  = 1'b1;
                t_skip = 32'(s_data.arity);
            end else begin
                wr_en       = (size_reg != '0);
                t_top_cnt   = s_data.arity;
                t_top_first = s_data.is_apply;
                t_size      = size_reg + 1'b1;
            end
        end

        if (do_reload) begin
            t_need_read = (t_size != '0);
            t_cont      = do_close;
        end else if (do_close && t_size != '0) begin
            if (top_cnt_reg != 16'd1) begin
                t_top_cnt   = top_cnt_reg - 16'd1;
                t_top_first = 1'b0;
            end else begin
                t_size      = size_m1;
                t_need_read = (size_m1 != '0);
                t_cont      = 1'b1;
            end
        end
    end

    always_comb begin
        c_size      = size_reg;
        c_top_cnt   = rd_cnt_reg;
        c_top_first = rd_first_reg;
        c_need_read = 1'b0;
        if (cont_reg) begin
            if (rd_cnt_reg != 16'd1) begin
                c_top_cnt   = rd_cnt_reg - 16'd1;
                c_top_first = 1'b0;
            end else begin
                c_size      = size_m1;
                c_need_read = (size_m1 != '0);
            end
        end
    end

    always_comb begin
        last_cur   = cmd.check ? m_data_reg.formula_end : s_data.last_token;
        f_size     = cmd.check ? c_size : t_size;
        f_skip     = cmd.check ? skip_reg : t_skip;
        mal_fin    = (cmd.check ? mal_pend_reg : t_mal)
                   || (last_cur && (f_size != '0 || f_skip != 32'd0));
        ovf_fin    = cmd.check ? ovf_pend_reg : t_ovf;
        status_fin = mal_fin ? STATUS_MAL : (ovf_fin ? STATUS_OVF : STATUS_OK);
    end

    always_comb begin
        stat.out_busy      = m_valid_reg;
        stat.tok_need_read = t_need_read;
        stat.chk_need_read = c_need_read;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= '0;
            skip_reg    <= 32'd0;
            kept_reg    <= 16'd0;
            at_root_reg <= 1'b1;
            md_reg      <= 8'd0;
            cont_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                md_reg <= cfg_data;
            end
            if (cmd.take) begin
                size_reg    <= t_size;
                skip_reg    <= t_skip;
                kept_reg    <= t_kept;
                at_root_reg <= 1'b0;
                cont_reg    <= t_cont;
            end else if (cmd.check) begin
                size_reg <= c_size;
            end
            if (cmd.finish && last_cur) begin
                size_reg    <= '0;
                skip_reg    <= 32'd0;
                kept_reg    <= 16'd0;
                at_root_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            top_cnt_reg             <= t_top_cnt;
            top_first_reg           <= t_top_first;
            mal_pend_reg            <= t_mal;
            ovf_pend_reg            <= t_ovf;
            m_data_reg.keep         <= t_keep;
            m_data_reg.out_token_id <= s_data.token_id;
            m_data_reg.out_arity    <= s_data.arity;
            m_data_reg.kept_count   <= t_kept;
            m_data_reg.formula_end  <= s_data.last_token;
        end else if (cmd.check) begin
            top_cnt_reg   <= c_top_cnt;
            top_first_reg <= c_top_first;
        end
        if (cmd.finish) begin
            m_data_reg.status <= status_fin;
        end
    end

    // stack memory: entries below the cached top
    always_ff @(posedge aclk) begin
        if (cmd.take && wr_en) begin
            cnt_mem[top_addr]   <= top_cnt_reg;
            first_mem[top_addr] <= top_first_reg;
        end
        if (cmd.read) begin
            rd_cnt_reg   <= cnt_mem[top_addr];
            rd_first_reg <= first_mem[top_addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/prefix_tree_depth_pruner.sv =====
// ----------------------------------------------------------------------------
// prefix_tree_depth_pruner
// Marks which prefix-order tree tokens survive a depth cutoff and counts the
// kept tokens of each formula.
//
//   channel   ports                       payload
//   input     s_valid / s_ready / s_data  token_id, arity, is_apply, last_token
//   result    m_valid / m_ready / m_data  keep, id, arity, kept_count, end, status
//   config    cfg_valid / cfg_ready       cfg_data = cut depth
//
// a token is taken in the idle state; each stack pop that exposes a stored
// entry also adds a stack memory read state and a check state
// the single-port stack memory with registered read sets the cascade cost
// reset is synchronous and clears control state; stack memory is not cleared
// s_ready is low during a pop cascade and while an untaken result is held
// ----------------------------------------------------------------------------
module prefix_tree_depth_pruner #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ptdp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ptdp_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);
    import ptdp_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    ptdp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptdp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== sv/ptdp_checker.sv =====
// ----------------------------------------------------------------------------
// ptdp_checker
// Port-level checks for the prefix tree depth pruner, bound to the top level.
// ----------------------------------------------------------------------------
module ptdp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ptdp_pkg::out_item_t m_data
);
    import ptdp_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a held result transaction keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("held result changed");

    // no input transaction while an untaken result waits
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid || m_ready)
        else $error("input taken over a pending result");

    // status code is one of the defined values
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("undefined status");

    // a kept token is counted
    a_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.keep |-> m_data.kept_count != 16'd0)
        else $error("kept token with zero count");

endmodule

bind prefix_tree_depth_pruner ptdp_checker u_ptdp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the prefix tree depth pruner. A directed table
// covers reset behavior, the zero cutoff, malformed formulas and the field
// extremes. Random formulas follow, mostly well-formed trees, deep chains
// that can run past the stack, cut-short and over-long formulas and raw noise,
// under several cutoffs and idling patterns. Each result is checked against
// its typed table entry or else a cycle-free model of the pruning rules.
// ----------------------------------------------------------------------------
module testbench;
    import ptdp_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int PHASE_ITEMS  = 225;
    localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_GAP      = 30;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum logic {ROW_TOKEN, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  depth;
        in_item_t    tok;
        logic        typed;
        logic        keep;
        logic [15:0] kept;
        logic [1:0]  status;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [24] = '{
        '{ROW_TOKEN, 8'd0, '{32'h0000_0000, 16'd0, 1'b0, 1'b1}, 1'b1, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'hFFFF_FFFF, 16'd2, 1'b1, 1'b0}, 1'b1, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0001, 16'd0, 1'b0, 1'b0}, 1'b1, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0002, 16'd0, 1'b0, 1'b1}, 1'b1, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0003, 16'd1, 1'b0, 1'b1}, 1'b1, 1'b0, 16'd0, STATUS_MAL},
        '{ROW_CFG, 8'd255, '0, 1'b0, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'hFFFF_FFFF, 16'd0, 1'b0, 1'b1}, 1'b1, 1'b1, 16'd1, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'hA5A5_5A5A, 16'hFFFF, 1'b0, 1'b1}, 1'b1, 1'b1, 16'd1, STATUS_MAL},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0010, 16'd1, 1'b1, 1'b0}, 1'b1, 1'b1, 16'd1, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0011, 16'd0, 1'b0, 1'b0}, 1'b1, 1'b1, 16'd2, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0012, 16'd3, 1'b1, 1'b0}, 1'b1, 1'b0, 16'd2, STATUS_MAL},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0013, 16'd0, 1'b0, 1'b1}, 1'b1, 1'b0, 16'd2, STATUS_MAL},
        '{ROW_CFG, 8'd1, '0, 1'b0, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0020, 16'd2, 1'b1, 1'b0}, 1'b0, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0021, 16'd0, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0022, 16'd2, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0023, 16'd0, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0024, 16'd0, 1'b0, 1'b1}, 1'b0, 1'b0, 16'd0, STATUS_OK},
        '{ROW_CFG, 8'd2, '0, 1'b0, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0030, 16'd2, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0031, 16'd1, 1'b1, 1'b0}, 1'b0, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0032, 16'd1, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0033, 16'd0, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0, STATUS_OK},
        '{ROW_TOKEN, 8'd0, '{32'h0000_0034, 16'd0, 1'b1, 1'b1}, 1'b0, 1'b0, 16'd0, STATUS_OK}
    };

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    prefix_tree_depth_pruner #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // pruning state of the model
    logic [15:0] open_left  [STACK_DEPTH];
    logic        open_first [STACK_DEPTH];
    int unsigned open_depth = 0;
    logic [31:0] skip_left  = '0;
    logic [15:0] kept_run   = '0;
    logic        want_root  = 1'b1;
    logic [7:0]  cut_depth  = 8'd0;

    out_item_t   expected_results [$];
    in_item_t    formula [$];
    logic        typed_valid;
    out_item_t   typed_result;
    idle_mode_t  idle_mode = IDLE_NONE;
    int          holds_requested = 0;
    int          holds_done = 0;
    int          mismatch_count = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("** prefix_tree_depth_pruner: FAILED **");
        $finish;
    end

    function automatic void pop_finished();
        while (open_depth > 0) begin
            if (open_left[open_depth - 1] != 16'd1) begin
                open_left[open_depth - 1]  = open_left[open_depth - 1] - 16'd1;
                open_first[open_depth - 1] = 1'b0;
                return;
            end
            open_depth--;
        end
    endfunction

    function automatic void skip_token(input logic [15:0] ar, inout logic ovf);
        logic [32:0] sum;
        sum = {1'b0, skip_left} - 33'd1 + {17'd0, ar};
        if (sum[32]) begin
            skip_left = '1;
            ovf = 1'b1;
        end else begin
            skip_left = sum[31:0];
        end
        if (skip_left == 32'd0)
            pop_finished();
    endfunction

    function automatic void take_token(input logic [15:0] ar, input logic apply, inout logic ovf);
        if (kept_run != 16'hFFFF)
            kept_run++;
        if (ar == 16'd0) begin
            pop_finished();
        end else if (open_depth >= STACK_DEPTH) begin
            ovf = 1'b1;
            skip_left = {16'd0, ar};
        end else begin
            open_left[open_depth]  = ar;
            open_first[open_depth] = apply;
            open_depth++;
        end
    endfunction

    function automatic out_item_t prune_step(input in_item_t t);
        logic      keep;
        logic      ovf;
        logic      bad;
        out_item_t r;
        keep = 1'b0;
        ovf  = 1'b0;
        bad  = 1'b0;
        if (want_root) begin
            want_root = 1'b0;
            if (cut_depth == 8'd0) begin
                skip_left = 32'd1;
                skip_token(t.arity, ovf);
            end else begin
                keep = 1'b1;
                take_token(t.arity, t.is_apply, ovf);
            end
        end else if (open_depth == 0 && skip_left == 32'd0) begin
            bad = 1'b1;
        end else if (skip_left != 32'd0) begin
            skip_token(t.arity, ovf);
        end else if (open_depth >= cut_depth && !open_first[open_depth - 1]) begin
            skip_left = {16'd0, open_left[open_depth - 1]};
            open_depth--;
            skip_token(t.arity, ovf);
        end else begin
            keep = 1'b1;
            take_token(t.arity, t.is_apply, ovf);
        end
        if (t.last_token && (open_depth != 0 || skip_left != 32'd0))
            bad = 1'b1;
        r.keep         = keep;
        r.out_token_id = t.token_id;
        r.out_arity    = t.arity;
        r.kept_count   = kept_run;
        r.formula_end  = t.last_token;
        r.status       = bad ? STATUS_MAL : (ovf ? STATUS_OVF : STATUS_OK);
        if (t.last_token) begin
            open_depth = 0;
            skip_left  = '0;
            kept_run   = '0;
            want_root  = 1'b1;
        end
        return r;
    endfunction

    // transaction bookkeeping and result checks
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                cut_depth = cfg_data;
            if (s_valid && s_ready) begin
                want = prune_step(s_data);
                if (typed_valid)
                    want = typed_result;
                expected_results = {expected_results, want};
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result id=%h with nothing pending", $time,
                                 m_data.out_token_id);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.keep !== want.keep || m_data.out_token_id !== want.out_token_id ||
                        m_data.out_arity !== want.out_arity ||
                        m_data.kept_count !== want.kept_count ||
                        m_data.formula_end !== want.formula_end ||
                        m_data.status !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: mismatch expected keep=%0b id=%h arity=%0d kept=%0d",
                                      " end=%0b status=%0d, got keep=%0b id=%h arity=%0d",
                                      " kept=%0d end=%0b status=%0d"}, $time,
                                     want.keep, want.out_token_id, want.out_arity,
                                     want.kept_count, want.formula_end, want.status,
                                     m_data.keep, m_data.out_token_id, m_data.out_arity,
                                     m_data.kept_count, m_data.formula_end, m_data.status);
                    end
                end
            end
        end
    end

    initial begin
        int stall_pct;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_done < holds_requested) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_done++;
            end
            stall_pct = (idle_mode == IDLE_RECEIVER) ? 70 : (idle_mode == IDLE_BOTH) ? 12 : 0;
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic int sender_gap();
        int gap;
        int pct;
        gap = 0;
        pct = (idle_mode == IDLE_SENDER) ? 70 : (idle_mode == IDLE_BOTH) ? 12 : 0;
        while (gap < MAX_GAP && $urandom_range(99) < pct)
            gap++;
        return gap;
    endfunction

    task automatic send_token(input in_item_t t, input logic has_typed, input out_item_t typed);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data       <= t;
        typed_valid  <= has_typed;
        typed_result <= typed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_cut_depth(input logic [7:0] depth);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= depth;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic build_formula();
        int       pick;
        int       n;
        int       cut;
        int       open_slots;
        int       budget;
        logic     chain_apply;
        in_item_t t;
        formula.delete();
        pick = $urandom_range(99);
        if (pick < 8) begin
            // chain that can run deeper than the stack
            n = $urandom_range(60, 72);
            chain_apply = ($urandom_range(3) != 0);
            repeat (n) begin
                t.token_id   = $urandom;
                t.arity      = 16'd1;
                t.is_apply   = chain_apply | 1'($urandom_range(1));
                t.last_token = 1'b0;
                formula = {formula, t};
            end
            t.token_id   = $urandom;
            t.arity      = 16'd0;
            t.is_apply   = 1'($urandom_range(1));
            t.last_token = 1'b1;
            formula = {formula, t};
        end else if (pick < 95) begin
            open_slots = 1;
            budget = $urandom_range(1, 40);
            while (open_slots > 0) begin
                if (formula.size() + open_slots >= budget)
                    t.arity = 16'd0;
                else if ($urandom_range(15) == 0)
                    t.arity = 16'($urandom_range(4, 9));
                else
                    t.arity = 16'($urandom_range(3));
                t.token_id   = $urandom;
                t.is_apply   = 1'($urandom_range(1));
                t.last_token = 1'b0;
                formula = {formula, t};
                open_slots += int'(t.arity) - 1;
            end
            formula[formula.size() - 1].last_token = 1'b1;
            if (pick >= 72 && pick < 84 && formula.size() > 1) begin
                // cut short
                cut = $urandom_range(formula.size() - 2);
                while (formula.size() > cut + 1)
                    void'(formula.pop_back());
                formula[formula.size() - 1].last_token = 1'b1;
            end else if (pick >= 84) begin
                // tokens past the complete tree
                formula[formula.size() - 1].last_token = 1'b0;
                repeat ($urandom_range(1, 3)) begin
                    t.token_id   = $urandom;
                    t.arity      = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3));
                    t.is_apply   = 1'($urandom_range(1));
                    t.last_token = 1'b0;
                    formula = {formula, t};
                end
                formula[formula.size() - 1].last_token = 1'b1;
            end
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                t.token_id   = $urandom;
                t.arity      = 16'($urandom);
                t.is_apply   = 1'($urandom_range(1));
                t.last_token = ($urandom_range(4) == 0);
                formula = {formula, t};
            end
            formula[formula.size() - 1].last_token = 1'b1;
        end
    endtask

    task automatic run_random_phase(input logic [7:0] depth, input idle_mode_t mode,
                                    input logic squeeze);
        int sent;
        sent = 0;
        write_cut_depth(depth);
        idle_mode = mode;
        if (squeeze)
            holds_requested++;
        while (sent < PHASE_ITEMS) begin
            build_formula();
            sent += formula.size();
            while (formula.size() != 0)
                send_token(formula.pop_front(), 1'b0, '0);
        end
    endtask

    initial begin
        stim_row_t row;
        out_item_t typed;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        typed_valid  = 1'b0;
        typed_result = '0;
        cfg_valid    = 1'b0;
        cfg_data     = 8'd0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_CFG) begin
                write_cut_depth(row.depth);
            end else begin
                typed = '{row.keep, row.tok.token_id, row.tok.arity, row.kept,
                          row.tok.last_token, row.status};
                send_token(row.tok, row.typed, typed);
            end
        end

        run_random_phase(8'd3, IDLE_NONE, 1'b1);
        run_random_phase(8'd255, IDLE_SENDER, 1'b0);
        run_random_phase(8'd0, IDLE_RECEIVER, 1'b0);
        run_random_phase(8'd1, IDLE_BOTH, 1'b0);
        run_random_phase(8'd2, IDLE_SENDER, 1'b0);
        run_random_phase(8'd64, IDLE_RECEIVER, 1'b0);
        run_random_phase(8'($urandom_range(4, 20)), IDLE_BOTH, 1'b0);
        run_random_phase(8'd128, IDLE_NONE, 1'b0);

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("** prefix_tree_depth_pruner: PASSED **");
        else
            $display("** prefix_tree_depth_pruner: FAILED **");
        $finish;
    end

endmodule
